// ----- rtl/rfb_pkg.sv -----
// Shared types, codes and constants for the rotated framebuffer block.
// Holds the input and result beat structs and the dirty rectangle struct.
// No dependencies.
`timescale 1ns / 1ps

package rfb_pkg;

  localparam int COORD_W = 10;
  localparam int PIX_W   = 16;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [PIX_W-1:0]   pixel_t;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_OOB   = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [1:0] REG_PHYS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_PHYS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ORIENTATION = 2'd2;

  localparam coord_t     PHYS_WIDTH_RST  = 10'd320;
  localparam coord_t     PHYS_HEIGHT_RST = 10'd240;
  localparam logic [1:0] ORIENT_RST      = 2'd0;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        changed;
    logic [8:0]  rect_left;
    logic [8:0]  rect_top;
    logic [9:0]  rect_right;
    logic [9:0]  rect_bottom;
    logic [19:0] byte_count;
    logic [15:0] pixel_word;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    coord_t      min_x;
    coord_t      max_x;
    coord_t      min_y;
    coord_t      max_y;
    logic [19:0] bytes;
  } dirty_rect_t;

  // Five bits of red, six of green and five of blue.
  function automatic pixel_t pack_rgb565(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ----- rtl/rfb_wrap.sv -----
// Iterative remainder unit: wraps one coordinate modulo the logical size.
// Restoring division, two quotient bits per cycle. Depends on rfb_pkg.
`timescale 1ns / 1ps

module rfb_wrap import rfb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start_i,
  input  coord_t dividend_i,
  input  coord_t divisor_i,
  output logic   done_o,
  output coord_t rem_o
);

  localparam int STEPS = COORD_W / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [CW-1:0] cnt_r;
  coord_t        num_r, div_r, rem_r;
  coord_t        num_nxt, rem_nxt;

  always_comb begin
    logic [COORD_W:0] t;
    coord_t r;
    coord_t n;
    r = rem_r;
    n = num_r;
    for (int i = 0; i < 2; i++) begin
      t = {r, n[COORD_W-1]};
      n = {n[COORD_W-2:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      r = t[COORD_W-1:0];
    end
    rem_nxt = r;
    num_nxt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start_i) begin
      cnt_r <= CW'(STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      num_r <= dividend_i;
      div_r <= divisor_i;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done_o = (cnt_r == '0);
  assign rem_o  = rem_r;

endmodule

// ----- rtl/rfb_store.sv -----
// Pixel memory: one synchronous port pair with registered read data.
// After reset it sweeps every entry to black, one word a cycle. Depends on rfb_pkg.
`timescale 1ns / 1ps

module rfb_store import rfb_pkg::*; #(
  parameter int AW    = 18,
  parameter int DEPTH = 262144
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] addr_i,
  input  pixel_t        wr_data_i,
  output pixel_t        rd_data_o,
  output logic          clearing_o
);

  pixel_t        mem [DEPTH];
  pixel_t        rd_data_r;
  logic [AW-1:0] clr_idx_r;
  logic          clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en_i) begin
      mem[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_r <= mem[addr_i];
    end
  end

  assign rd_data_o  = rd_data_r;
  assign clearing_o = clearing_r;

endmodule

// ----- rtl/rfb_dirty.sv -----
// Dirty rectangle tracker with a registered byte count of its area.
// Widens on changed pixels, empties on flush. Depends on rfb_pkg.
`timescale 1ns / 1ps

module rfb_dirty import rfb_pkg::*; #(
  parameter coord_t RST_MAX_X = 10'd319,
  parameter coord_t RST_MAX_Y = 10'd239
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        upd_i,
  input  logic        clr_i,
  input  coord_t      x_i,
  input  coord_t      y_i,
  output dirty_rect_t rect_o
);

  logic        valid_r;
  coord_t      min_x_r, max_x_r, min_y_r, max_y_r;
  coord_t      w, h;
  logic [19:0] area_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b1;
      min_x_r <= '0;
      max_x_r <= RST_MAX_X;
      min_y_r <= '0;
      max_y_r <= RST_MAX_Y;
    end else if (clr_i) begin
      valid_r <= 1'b0;
      min_x_r <= '0;
      max_x_r <= '0;
      min_y_r <= '0;
      max_y_r <= '0;
    end else if (upd_i) begin
      valid_r <= 1'b1;
      if (!valid_r) begin
        min_x_r <= x_i;
        max_x_r <= x_i;
        min_y_r <= y_i;
        max_y_r <= y_i;
      end else begin
        if (x_i < min_x_r) min_x_r <= x_i;
        if (x_i > max_x_r) max_x_r <= x_i;
        if (y_i < min_y_r) min_y_r <= y_i;
        if (y_i > max_y_r) max_y_r <= y_i;
      end
    end
  end

  assign w = max_x_r - min_x_r + 1'b1;
  assign h = max_y_r - min_y_r + 1'b1;

  // The area is registered from the bounds; a flush reads it in S_FLUSH.
  always_ff @(posedge clk) begin
    area_r <= {10'd0, w} * {10'd0, h};
  end

  assign rect_o = '{valid: valid_r, min_x: min_x_r, max_x: max_x_r,
                    min_y: min_y_r, max_y: max_y_r, bytes: {area_r[18:0], 1'b0}};

endmodule

// ----- rtl/rotated_framebuffer_dirty_rect.sv -----
// Top level of the rotated RGB565 framebuffer with dirty rectangle tracking.
// Instantiates rfb_wrap (twice), rfb_store and rfb_dirty; depends on rfb_pkg.
`timescale 1ns / 1ps

// One item is in flight at a time. A pixel write passes from acceptance through
// S_WRAP, where the shared-nothing pair of remainder units wraps x and y (five
// steps of two bits each), S_MAP for the orientation mapping, and S_WR_RD and
// S_WR_CMP for the read-compare-write of the pixel memory with its registered
// read data, then returns to S_IDLE. A read goes through S_RD_RD and S_RD_DATA,
// a flush through S_FLUSH, any out-of-range item or unused op through S_EMIT.
// After reset the pixel memory is swept to black, one word a cycle, over all
// MAX_HEIGHT * 2**clog2(MAX_WIDTH) words (262144 at the defaults); no item is
// taken in that time, but configuration writes are. The result register lets an
// item be accepted while the previous result beat still waits; a result that
// finds the register occupied holds the block until it is taken.
module rotated_framebuffer_dirty_rect import rfb_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = MAX_HEIGHT * (2 ** XW);

  function automatic coord_t eff_size(input coord_t v, input int mx);
    coord_t r;
    if (v == '0) begin
      r = 10'd1;
    end else if (int'(v) > mx) begin
      r = COORD_W'(mx);
    end else begin
      r = v;
    end
    return r;
  endfunction

  localparam coord_t RST_MAX_X = eff_size(PHYS_WIDTH_RST, MAX_WIDTH) - 10'd1;
  localparam coord_t RST_MAX_Y = eff_size(PHYS_HEIGHT_RST, MAX_HEIGHT) - 10'd1;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_WRAP    = 9'b000000010,
    S_MAP     = 9'b000000100,
    S_WR_RD   = 9'b000001000,
    S_WR_CMP  = 9'b000010000,
    S_RD_RD   = 9'b000100000,
    S_RD_DATA = 9'b001000000,
    S_FLUSH   = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  coord_t      phys_width_r, phys_height_r;
  logic [1:0]  orient_r;
  in_item_t    item_r, item_nxt;
  out_item_t   pend_r, pend_nxt;
  out_item_t   out_r, res;
  logic        out_valid_r;
  logic        emit, slot_free;
  coord_t      map_x_r, map_y_r;
  logic        map_oob_r;
  coord_t      map_x, map_y;
  logic        map_oob;

  coord_t      pw, ph, lw, lh;
  logic        portrait, rotate, flip;

  logic        wrap_start, done_x, done_y;
  coord_t      rem_x, rem_y;

  logic        mem_rd, mem_we, clearing;
  logic [AW-1:0] mem_addr;
  pixel_t      rd_data, word;

  logic        dirty_upd, dirty_clr;
  dirty_rect_t rect;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phys_width_r  <= PHYS_WIDTH_RST;
      phys_height_r <= PHYS_HEIGHT_RST;
      orient_r      <= ORIENT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PHYS_WIDTH:  phys_width_r  <= cfg_data;
        REG_PHYS_HEIGHT: phys_height_r <= cfg_data;
        REG_ORIENTATION: orient_r      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Logical geometry follows from the panel shape and the orientation.
  assign pw       = eff_size(phys_width_r, MAX_WIDTH);
  assign ph       = eff_size(phys_height_r, MAX_HEIGHT);
  assign portrait = pw < ph;
  assign rotate   = portrait ? !orient_r[0] : orient_r[0];
  assign flip     = (!portrait && rotate) ^ orient_r[1];
  assign lw       = rotate ? ph : pw;
  assign lh       = rotate ? pw : ph;

  rfb_wrap u_wrap_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (wrap_start),
    .dividend_i (in_data.pos_x),
    .divisor_i  (lw),
    .done_o     (done_x),
    .rem_o      (rem_x)
  );

  rfb_wrap u_wrap_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (wrap_start),
    .dividend_i (in_data.pos_y),
    .divisor_i  (lh),
    .done_o     (done_y),
    .rem_o      (rem_y)
  );

  // Flip, then rotate a quarter turn, from the wrapped logical position.
  always_comb begin
    coord_t fx;
    coord_t fy;
    logic   oob_rot;
    fx      = flip ? (lw - 1'b1 - rem_x) : rem_x;
    fy      = flip ? (lh - 1'b1 - rem_y) : rem_y;
    oob_rot = 1'b0;
    if (rotate) begin
      oob_rot = fx >= ph;
      map_x   = fy;
      map_y   = ph - 1'b1 - fx;
    end else begin
      map_x = fx;
      map_y = fy;
    end
    map_oob = oob_rot || (map_x >= pw) || (map_y >= ph);
  end

  rfb_store #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en_i    (mem_rd),
    .wr_en_i    (mem_we),
    .addr_i     (mem_addr),
    .wr_data_i  (word),
    .rd_data_o  (rd_data),
    .clearing_o (clearing)
  );

  rfb_dirty #(
    .RST_MAX_X (RST_MAX_X),
    .RST_MAX_Y (RST_MAX_Y)
  ) u_dirty (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_i  (dirty_upd),
    .clr_i  (dirty_clr),
    .x_i    (map_x_r),
    .y_i    (map_y_r),
    .rect_o (rect)
  );

  assign word      = pack_rgb565(item_r.red, item_r.green, item_r.blue);
  assign mem_addr  = (state_r == S_RD_RD) ? {YW'(item_r.pos_y), XW'(item_r.pos_x)}
                                          : {YW'(map_y_r), XW'(map_x_r)};
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && !clearing;

  // Accesses to the memory are strictly ordered: an item's write lands before
  // the next item can issue its read, so no forwarding is needed.
  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    pend_nxt   = pend_r;
    res        = '0;
    emit       = 1'b0;
    wrap_start = 1'b0;
    mem_rd     = 1'b0;
    mem_we     = 1'b0;
    dirty_upd  = 1'b0;
    dirty_clr  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          item_nxt = in_data;
          case (in_data.op)
            OP_WRITE: begin
              wrap_start = 1'b1;
              state_nxt  = S_WRAP;
            end
            OP_FLUSH: state_nxt = S_FLUSH;
            OP_READ: begin
              if ((in_data.pos_x < pw) && (in_data.pos_y < ph)) begin
                state_nxt = S_RD_RD;
              end else begin
                pend_nxt        = '0;
                pend_nxt.status = STATUS_OOB;
                state_nxt       = S_EMIT;
              end
            end
            default: begin
              pend_nxt  = '0;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_WRAP: begin
        if (done_x && done_y) state_nxt = S_MAP;
      end
      S_MAP: state_nxt = S_WR_RD;
      S_WR_RD: begin
        if (map_oob_r) begin
          pend_nxt        = '0;
          pend_nxt.status = STATUS_OOB;
          state_nxt       = S_EMIT;
        end else begin
          mem_rd    = 1'b1;
          state_nxt = S_WR_CMP;
        end
      end
      S_WR_CMP: begin
        if (slot_free) begin
          res.status  = STATUS_OK;
          res.changed = (rd_data != word);
          mem_we      = res.changed;
          dirty_upd   = res.changed;
          emit        = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_RD_RD: begin
        mem_rd    = 1'b1;
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (slot_free) begin
          res.pixel_word = rd_data;
          emit           = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          if (rect.valid) begin
            res.rect_left   = rect.min_x[8:0];
            res.rect_top    = rect.min_y[8:0];
            res.rect_right  = rect.max_x + 1'b1;
            res.rect_bottom = rect.max_y + 1'b1;
            res.byte_count  = rect.bytes;
          end else begin
            res.status = STATUS_EMPTY;
          end
          dirty_clr = 1'b1;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          res       = pend_r;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (out_valid_r && !out_ready) || emit;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    pend_r <= pend_nxt;
    if (emit) begin
      out_r <= res;
    end
    if (state_r == S_MAP) begin
      map_x_r   <= map_x;
      map_y_r   <= map_y;
      map_oob_r <= map_oob;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A changed pixel always leaves a valid dirty rectangle behind it.
  a_dirty_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    dirty_upd |=> rect.valid)
    else $error("dirty rectangle not valid after a changed pixel");

  // A flush empties the rectangle and leaves its result beat pending.
  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) && slot_free |=> !rect.valid && out_valid_r)
    else $error("flush did not empty the dirty rectangle");

  // The compare only ever sees data from a read issued for this write.
  a_compare_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR_CMP) |-> $past(state_r == S_WR_RD) || $past(state_r == S_WR_CMP))
    else $error("pixel compare without a preceding memory read");

  // No item is taken while the memory is being swept to black.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("item accepted during the clearing pass");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the rotated RGB565 framebuffer with dirty rectangle tracking.
// A predictor of pixel writes, flushes and reads checks every result beat.
// Depends on rfb_pkg and rotated_framebuffer_dirty_rect.
`timescale 1ns / 1ps

module testbench;
  import rfb_pkg::*;

  localparam int MAXW = 512;
  localparam int MAXH = 512;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int STALL_LIMIT = 800000;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_PHYS_WIDTH;
  logic [9:0] cfg_data = '0;

  // Predictor state: the panel setup, the stored words and the dirty rectangle.
  logic [9:0] panel_w = PHYS_WIDTH_RST;
  logic [9:0] panel_h = PHYS_HEIGHT_RST;
  logic [1:0] orient = ORIENT_RST;
  bit [15:0] fb_mem [0:MAXW*MAXH-1];
  bit rect_on = 1'b1;
  int unsigned rect_x0 = 0;
  int unsigned rect_x1 = PHYS_WIDTH_RST - 1;
  int unsigned rect_y0 = 0;
  int unsigned rect_y1 = PHYS_HEIGHT_RST - 1;
  int unsigned touched_x[$];
  int unsigned touched_y[$];

  out_item_t fb_replies_due[$];
  int fail_count = 0;
  int unsigned idle_cycles = 0;
  bit no_gaps = 1'b0;

  rotated_framebuffer_dirty_rect u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_size(logic [9:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic in_item_t mk_item(logic [1:0] op, int unsigned x, int unsigned y,
                                       logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_item_t it;
    it.op = op;
    it.pos_x = x[9:0];
    it.pos_y = y[9:0];
    it.red = r;
    it.green = g;
    it.blue = b;
    return it;
  endfunction

  // Works out the result beat of one accepted item and advances the predictor state.
  function automatic out_item_t predict_fb_reply(in_item_t it);
    out_item_t res;
    int unsigned pw, ph, lw, lh, lx, ly, t, addr;
    bit portrait, rotate, flip;
    logic [15:0] word;
    res = '0;
    pw = clamp_size(panel_w, MAXW);
    ph = clamp_size(panel_h, MAXH);
    case (it.op)
      OP_WRITE: begin
        portrait = pw < ph;
        rotate = portrait ? !orient[0] : orient[0];
        flip = (!portrait && rotate) != orient[1];
        lw = rotate ? ph : pw;
        lh = rotate ? pw : ph;
        lx = it.pos_x % lw;
        ly = it.pos_y % lh;
        if (flip) begin
          lx = lw - 1 - lx;
          ly = lh - 1 - ly;
        end
        if (rotate) begin
          t = ly;
          ly = ph - 1 - lx;
          lx = t;
        end
        if (lx >= pw || ly >= ph) begin
          res.status = STATUS_OOB;
        end else begin
          word = {it.red & 8'hf8, 8'h00} | ({8'h00, it.green & 8'hfc} << 3) |
                 ({8'h00, it.blue} >> 3);
          addr = ly * MAXW + lx;
          if (touched_x.size() >= 32) begin
            void'(touched_x.pop_front());
            void'(touched_y.pop_front());
          end
          touched_x.push_back(lx);
          touched_y.push_back(ly);
          if (fb_mem[addr] != word) begin
            fb_mem[addr] = word;
            res.changed = 1'b1;
            if (!rect_on) begin
              rect_x0 = lx;
              rect_x1 = lx;
              rect_y0 = ly;
              rect_y1 = ly;
              rect_on = 1'b1;
            end else begin
              if (lx < rect_x0) rect_x0 = lx;
              if (lx > rect_x1) rect_x1 = lx;
              if (ly < rect_y0) rect_y0 = ly;
              if (ly > rect_y1) rect_y1 = ly;
            end
          end
        end
      end
      OP_FLUSH: begin
        if (!rect_on) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.rect_left = rect_x0[8:0];
          res.rect_top = rect_y0[8:0];
          res.rect_right = 10'(rect_x1 + 1);
          res.rect_bottom = 10'(rect_y1 + 1);
          res.byte_count = 20'((rect_x1 - rect_x0 + 1) * (rect_y1 - rect_y0 + 1) * 2);
          rect_on = 1'b0;
          rect_x0 = 0;
          rect_x1 = 0;
          rect_y0 = 0;
          rect_y1 = 0;
        end
      end
      OP_READ: begin
        if (it.pos_x >= pw || it.pos_y >= ph) res.status = STATUS_OOB;
        else res.pixel_word = fb_mem[it.pos_y * MAXW + it.pos_x];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) report_mismatch(name, got, want);
  endtask

  // Valid stays high across back-to-back beats; it is lowered only ahead of a gap.
  task automatic send_item(in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    fb_replies_due.push_back(predict_fb_reply(it));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (fb_replies_due.size() != 0);
  endtask

  // Writes all three registers once the block has drained.
  task automatic set_panel(logic [9:0] w, logic [9:0] h, logic [1:0] o);
    logic [1:0] idx [3] = '{REG_PHYS_WIDTH, REG_PHYS_HEIGHT, REG_ORIENTATION};
    logic [9:0] vals [3];
    vals = '{w, h, {8'd0, o}};
    wait_idle();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_PHYS_WIDTH:  panel_w = vals[i];
        REG_PHYS_HEIGHT: panel_h = vals[i];
        REG_ORIENTATION: orient = vals[i][1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_item(mk_item(OP_FLUSH, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_FLUSH, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_READ, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_READ, 319, 239, 0, 0, 0));
    send_item(mk_item(OP_READ, 320, 0, 0, 0, 0));
    send_item(mk_item(OP_READ, 0, 240, 0, 0, 0));
    send_item(mk_item(OP_NONE, 1023, 1023, 8'hff, 8'hff, 8'hff));
  endtask

  task automatic test_write_basics();
    send_item(mk_item(OP_WRITE, 0, 0, 8'hff, 8'hff, 8'hff));
    send_item(mk_item(OP_WRITE, 0, 0, 8'hff, 8'hff, 8'hff));
    // Low bits are dropped by the packing, so this leaves black as it was.
    send_item(mk_item(OP_WRITE, 1023, 1023, 8'h07, 8'h03, 8'h07));
    send_item(mk_item(OP_READ, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_FLUSH, 0, 0, 0, 0, 0));
  endtask

  task automatic test_orientations();
    for (int o = 0; o < 4; o++) begin
      set_panel(10'd16, 10'd8, o[1:0]);
      send_item(mk_item(OP_WRITE, 0, 0, 8'(8'h20 * (o + 1)), 8'h44, 8'h08));
      send_item(mk_item(OP_FLUSH, 0, 0, 0, 0, 0));
    end
    set_panel(10'd8, 10'd16, 2'd0);
    send_item(mk_item(OP_WRITE, 3, 1, 8'h80, 8'h80, 8'h80));
    send_item(mk_item(OP_FLUSH, 0, 0, 0, 0, 0));
  endtask

  // Sizes outside the legal range, and a rectangle carried across a size change.
  task automatic test_size_extremes();
    set_panel(10'd1023, 10'd0, 2'd0);
    send_item(mk_item(OP_WRITE, 1023, 5, 8'h12, 8'h34, 8'h56));
    set_panel(10'd0, 10'd1023, 2'd3);
    send_item(mk_item(OP_FLUSH, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_READ, 511, 0, 0, 0, 0));
    send_item(mk_item(OP_WRITE, 1023, 1023, 8'hf0, 8'h0f, 8'hff));
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [9:0] pick_side();
    case ($urandom_range(0, 7))
      0: return 10'd0;
      1: return 10'd1;
      2: return 10'd512;
      3: return 10'($urandom_range(513, 1023));
      4, 5: return 10'($urandom_range(1, 16));
      default: return 10'($urandom_range(1, 512));
    endcase
  endfunction

  task automatic random_items(int n);
    in_item_t it, last_wr;
    int sel, j;
    bit have_wr;
    have_wr = 1'b0;
    last_wr = '0;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      it = mk_item(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   pick_channel(), pick_channel(), pick_channel());
      if (sel < 15 && have_wr) begin
        // Same pixel, same colour: the store must report no change.
        it = last_wr;
      end else if (sel < 55) begin
        last_wr = it;
        have_wr = 1'b1;
      end else if (sel < 80) begin
        it.op = OP_READ;
        j = $urandom_range(0, 3);
        if (j < 2 && touched_x.size() > 0) begin
          j = $urandom_range(0, touched_x.size() - 1);
          it.pos_x = touched_x[j][9:0];
          it.pos_y = touched_y[j][9:0];
        end else if (j == 2) begin
          it.pos_x = 10'($urandom_range(0, clamp_size(panel_w, MAXW)));
          it.pos_y = 10'($urandom_range(0, clamp_size(panel_h, MAXH)));
        end
      end else if (sel < 96) begin
        it.op = OP_FLUSH;
      end else begin
        it.op = OP_NONE;
      end
      send_item(it);
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) set_panel(10'd512, 10'd512, 2'($urandom_range(0, 3)));
      else set_panel(pick_side(), pick_side(), 2'($urandom_range(0, 3)));
      no_gaps = ($urandom_range(0, 3) == 0);
      random_items(60);
    end
    no_gaps = 1'b0;
  endtask

  // Result side: a fresh stall is drawn for every beat.
  initial begin
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (fb_replies_due.size() == 0) begin
        report_mismatch("result beat with nothing expected", 64'(out_data.status), 64'd0);
      end else begin
        want = fb_replies_due.pop_front();
        check_field("status", 64'(out_data.status), 64'(want.status));
        check_field("changed", 64'(out_data.changed), 64'(want.changed));
        check_field("rect_left", 64'(out_data.rect_left), 64'(want.rect_left));
        check_field("rect_top", 64'(out_data.rect_top), 64'(want.rect_top));
        check_field("rect_right", 64'(out_data.rect_right), 64'(want.rect_right));
        check_field("rect_bottom", 64'(out_data.rect_bottom), 64'(want.rect_bottom));
        check_field("byte_count", 64'(out_data.byte_count), 64'(want.byte_count));
        check_field("pixel_word", 64'(out_data.pixel_word), 64'(want.pixel_word));
      end
    end
  end

  // The sweep to black after reset is the longest legitimate quiet spell.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main_flow
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_write_basics();
    test_orientations();
    test_size_extremes();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
